FILE: rtl/bts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types, sizes and helper functions of the bilinear thumbnail scaler.
// ----------------------------------------------------------------------------
package bts_pkg;

    parameter int MAX_SRC_WIDTH  = 256;
    parameter int MAX_SRC_HEIGHT = 256;

    parameter int X_W     = $clog2(MAX_SRC_WIDTH);
    parameter int Y_W     = $clog2(MAX_SRC_HEIGHT);
    parameter int COORD_W = (X_W > Y_W) ? X_W : Y_W;
    parameter int DEPTH   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    parameter int ADDR_W  = $clog2(DEPTH);

    parameter int CH_W    = 8;
    parameter int PIX_W   = 3 * CH_W;
    parameter int CFG_W   = 9;
    parameter int SCALE_W = 16;
    parameter int ODD_W   = CH_W + 1;
    parameter int PROD_W  = ODD_W + SCALE_W;
    parameter int FRAC_W  = 8;
    parameter int POS_SH  = 13;
    parameter int IDX_W   = PROD_W - POS_SH;
    parameter int HALF_PIX = 4096;
    parameter int WT_W    = FRAC_W + 1;
    parameter int TOP_W   = CH_W + WT_W;
    parameter int SUM_W   = TOP_W + WT_W;

    parameter int FIFO_DEPTH = 4;
    parameter int FIFO_AW    = $clog2(FIFO_DEPTH);
    parameter int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

    parameter int IDX_REG_W = 2;
    parameter logic [IDX_REG_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    parameter logic [IDX_REG_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    parameter logic [IDX_REG_W-1:0] CFG_INV_SCALE  = 2'd2;

    parameter logic MODE_WRITE   = 1'b0;
    parameter logic MODE_REQUEST = 1'b1;

    // one read slot per neighbour of the 2x2 footprint
    typedef enum logic [3:0] {
        PH_Q00 = 4'b0001,
        PH_Q10 = 4'b0010,
        PH_Q01 = 4'b0100,
        PH_Q11 = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [COORD_W-1:0] i0;
        logic [COORD_W-1:0] i1;
        logic [FRAC_W-1:0]  frac;
    } axis_t;

    typedef struct packed {
        logic              valid;
        phase_t            phase;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
        logic [CH_W-1:0]   col;
        logic [CH_W-1:0]   row;
    } rd_meta_t;

    typedef struct packed {
        logic [CH_W-1:0] col;
        logic [CH_W-1:0] row;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } blend_out_t;

    // largest usable index along one axis for a programmed size
    function automatic logic [COORD_W-1:0] size_lim(input logic [CFG_W-1:0] size, input int maxv);
        logic [COORD_W-1:0] lim;
        if (size == '0)
        begin
            lim = '0;
        end
        else if (int'(size) > maxv)
        begin
            lim = COORD_W'(maxv - 1);
        end
        else
        begin
            lim = COORD_W'(size - 1'b1);
        end
        return lim;
    endfunction

    // source position from the scaled pixel centre, clamped at both edges
    function automatic axis_t axis_map(input logic [PROD_W-1:0] prod,
                                       input logic [COORD_W-1:0] lim);
        logic [PROD_W-1:0] pos;
        logic [IDX_W-1:0]  a;
        axis_t             r;
        if (prod > PROD_W'(HALF_PIX))
        begin
            pos = prod - PROD_W'(HALF_PIX);
        end
        else
        begin
            pos = '0;
        end
        a = pos[PROD_W-1:POS_SH];
        if (int'(a) > int'(lim))
        begin
            r.i0 = lim;
        end
        else
        begin
            r.i0 = COORD_W'(a);
        end
        if (r.i0 >= lim)
        begin
            r.i1 = lim;
        end
        else
        begin
            r.i1 = r.i0 + 1'b1;
        end
        r.frac = pos[POS_SH-1 -: FRAC_W];
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bilinear_thumbnail_scaler.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a request's result is offered after the multiply, map and clamp stages, four
//   frame store reads and two blend stages; writes reach memory from stage 2.
// Throughput: the single frame store port reads the four neighbours one per cycle once
//   a credit is free; stage 2 stalls until the last read, else one write per cycle.
// Reset: control, pipeline and the three registers (256, 256, 1.0) are cleared at once;
//   the frame store has no clearing pass, its contents stay undefined until written.
// ----------------------------------------------------------------------------
// bilinear_thumbnail_scaler
// Frame store of a source RGB image with bilinear downscaled pixel lookup.
// ----------------------------------------------------------------------------
module bilinear_thumbnail_scaler
    import bts_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [IDX_REG_W-1:0] cfg_index,
    input  wire logic [SCALE_W-1:0]   cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 mode,
    input  wire logic [CH_W-1:0]      col,
    input  wire logic [CH_W-1:0]      row,
    input  wire logic [CH_W-1:0]      red_in,
    input  wire logic [CH_W-1:0]      green_in,
    input  wire logic [CH_W-1:0]      blue_in,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [CH_W-1:0]      out_col,
    output logic      [CH_W-1:0]      out_row,
    output logic      [CH_W-1:0]      red_out,
    output logic      [CH_W-1:0]      green_out,
    output logic      [CH_W-1:0]      blue_out
);

    // configuration
    logic [CFG_W-1:0]   src_width_reg;
    logic [CFG_W-1:0]   src_height_reg;
    logic [SCALE_W-1:0] inv_scale_reg;

    // stage 1: products of the pixel centres
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_mode_reg;
    logic [CH_W-1:0]    s1_col_reg;
    logic [CH_W-1:0]    s1_row_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic [PROD_W-1:0]  s1_prod_x_reg;
    logic [PROD_W-1:0]  s1_prod_y_reg;

    // stage 2: memory access sequencer
    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic               s2_mode_reg;
    logic               s2_wr_ok_reg;
    logic [CH_W-1:0]    s2_col_reg;
    logic [CH_W-1:0]    s2_row_reg;
    logic [PIX_W-1:0]   s2_pix_reg;
    axis_t              s2_ax_reg;
    axis_t              s2_ay_reg;
    phase_t             phase_reg;
    phase_t             phase_next;

    logic [CREDIT_W-1:0] credit_reg;
    logic [CREDIT_W-1:0] credit_next;

    rd_meta_t           rd_reg;
    rd_meta_t           rd_next;

    logic               in_xfer;
    logic               s1_adv;
    logic               s2_free;
    logic               s2_done;
    logic               s2_issue;
    logic               s2_start;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [PIX_W-1:0]   mem_rdata;
    logic [COORD_W-1:0] sel_x;
    logic [COORD_W-1:0] sel_y;
    axis_t              ax_next;
    axis_t              ay_next;

    // result queue
    result_t            fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [CREDIT_W-1:0] fifo_cnt_reg;
    logic [CREDIT_W-1:0] fifo_cnt_next;
    logic               out_xfer;
    blend_out_t         blend_res;
    result_t            head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= CFG_W'(256);
            src_height_reg <= CFG_W'(256);
            inv_scale_reg  <= SCALE_W'(4096);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[CFG_W-1:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data[CFG_W-1:0];
                CFG_INV_SCALE:  inv_scale_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // handshake and stage advance
    assign s2_start = s2_valid_reg && (s2_mode_reg == MODE_REQUEST) && (phase_reg == PH_Q00);
    assign s2_issue = s2_valid_reg && (s2_mode_reg == MODE_REQUEST)
                   && (!s2_start || (credit_reg < CREDIT_W'(FIFO_DEPTH)));
    assign s2_done  = s2_valid_reg
                   && ((s2_mode_reg == MODE_WRITE) || (phase_reg == PH_Q11));
    assign s2_free  = !s2_valid_reg || s2_done;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_stall = s1_valid_reg && !s2_free;
    assign in_xfer  = in_valid && !in_stall;

    assign s1_valid_next = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign s2_valid_next = s1_adv ? 1'b1 : (s2_done ? 1'b0 : s2_valid_reg);

    always_comb
    begin
        phase_next = phase_reg;
        if (s2_issue)
        begin
            case (phase_reg)
                PH_Q00:  phase_next = PH_Q10;
                PH_Q10:  phase_next = PH_Q01;
                PH_Q01:  phase_next = PH_Q11;
                PH_Q11:  phase_next = PH_Q00;
                default: phase_next = PH_Q00;
            endcase
        end
    end

    // one credit per request in flight or waiting in the queue
    assign out_xfer    = out_valid && !out_stall;
    assign credit_next = credit_reg + CREDIT_W'(s2_issue && s2_start) - CREDIT_W'(out_xfer);

    assign ax_next = axis_map(s1_prod_x_reg, size_lim(src_width_reg, MAX_SRC_WIDTH));
    assign ay_next = axis_map(s1_prod_y_reg, size_lim(src_height_reg, MAX_SRC_HEIGHT));

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_mode_reg   <= mode;
            s1_col_reg    <= col;
            s1_row_reg    <= row;
            s1_pix_reg    <= {red_in, green_in, blue_in};
            s1_prod_x_reg <= PROD_W'({col, 1'b1}) * PROD_W'(inv_scale_reg);
            s1_prod_y_reg <= PROD_W'({row, 1'b1}) * PROD_W'(inv_scale_reg);
        end
        if (s1_adv)
        begin
            s2_mode_reg  <= s1_mode_reg;
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
            s2_pix_reg   <= s1_pix_reg;
            s2_wr_ok_reg <= (int'(s1_col_reg) < MAX_SRC_WIDTH)
                         && (int'(s1_row_reg) < MAX_SRC_HEIGHT);
            s2_ax_reg    <= ax_next;
            s2_ay_reg    <= ay_next;
        end
    end

    // neighbour selection and frame store address
    always_comb
    begin
        sel_x = s2_ax_reg.i0;
        sel_y = s2_ay_reg.i0;
        case (phase_reg)
            PH_Q00:
            begin
                sel_x = s2_ax_reg.i0;
                sel_y = s2_ay_reg.i0;
            end
            PH_Q10:
            begin
                sel_x = s2_ax_reg.i1;
                sel_y = s2_ay_reg.i0;
            end
            PH_Q01:
            begin
                sel_x = s2_ax_reg.i0;
                sel_y = s2_ay_reg.i1;
            end
            PH_Q11:
            begin
                sel_x = s2_ax_reg.i1;
                sel_y = s2_ay_reg.i1;
            end
            default: ;
        endcase
        if (s2_mode_reg == MODE_WRITE)
        begin
            mem_addr = ADDR_W'(s2_row_reg) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(s2_col_reg);
        end
        else
        begin
            mem_addr = ADDR_W'(sel_y) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(sel_x);
        end
    end

    assign mem_we = s2_valid_reg && (s2_mode_reg == MODE_WRITE) && s2_wr_ok_reg;

    bts_frame_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (s2_issue),
        .addr  (mem_addr),
        .wdata (s2_pix_reg),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        rd_next.valid = s2_issue;
        rd_next.phase = phase_reg;
        rd_next.fx    = s2_ax_reg.frac;
        rd_next.fy    = s2_ay_reg.frac;
        rd_next.col   = s2_col_reg;
        rd_next.row   = s2_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            phase_reg    <= PH_Q00;
            credit_reg   <= '0;
            rd_reg       <= '{valid: 1'b0, phase: PH_Q00, default: '0};
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            phase_reg    <= phase_next;
            credit_reg   <= credit_next;
            rd_reg       <= rd_next;
        end
    end

    bts_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (rd_reg),
        .rdata (mem_rdata),
        .res   (blend_res)
    );

    // result queue, never full thanks to the credit count
    assign fifo_cnt_next = fifo_cnt_reg + CREDIT_W'(blend_res.valid) - CREDIT_W'(out_xfer);

    always_ff @(posedge clk)
    begin
        if (blend_res.valid)
        begin
            fifo_mem[wr_ptr_reg] <= blend_res.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (blend_res.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    assign head      = fifo_mem[rd_ptr_reg];
    assign out_valid = (fifo_cnt_reg != '0);
    assign out_col   = head.col;
    assign out_row   = head.row;
    assign red_out   = head.red;
    assign green_out = head.green;
    assign blue_out  = head.blue;

endmodule
`default_nettype wire

FILE: rtl/bts_frame_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bts_frame_store
// Single-port source image memory with a registered read port.
// ----------------------------------------------------------------------------
module bts_frame_store
    import bts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [PIX_W-1:0]  wdata,
    output logic      [PIX_W-1:0]  rdata
);

    logic [PIX_W-1:0] frame_mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            frame_mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= frame_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/bts_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bts_blend
// Gathers the four neighbours of a request and blends each channel
// bilinearly in two multiply stages.
// ----------------------------------------------------------------------------
module bts_blend
    import bts_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rd_meta_t         rd,
    input  wire logic [PIX_W-1:0] rdata,
    output blend_out_t            res
);

    logic [PIX_W-1:0]  p00_reg;
    logic [PIX_W-1:0]  p10_reg;
    logic [PIX_W-1:0]  p01_reg;

    logic              b1_valid_reg;
    logic              b1_valid_next;
    logic [TOP_W-1:0]  b1_top_reg  [3];
    logic [TOP_W-1:0]  b1_bot_reg  [3];
    logic [TOP_W-1:0]  b1_top_next [3];
    logic [TOP_W-1:0]  b1_bot_next [3];
    logic [FRAC_W-1:0] b1_fy_reg;
    logic [CH_W-1:0]   b1_col_reg;
    logic [CH_W-1:0]   b1_row_reg;

    logic [CH_W-1:0]   chan_out [3];

    always_ff @(posedge clk)
    begin
        if (rd.valid)
        begin
            case (rd.phase)
                PH_Q00:  p00_reg <= rdata;
                PH_Q10:  p10_reg <= rdata;
                PH_Q01:  p01_reg <= rdata;
                default: ;
            endcase
        end
    end

    assign b1_valid_next = rd.valid && (rd.phase == PH_Q11);

    // horizontal blend of both rows, last neighbour straight from the read port
    always_comb
    begin
        logic [TOP_W-1:0] wx1;
        logic [TOP_W-1:0] wx0;
        wx1 = TOP_W'(rd.fx);
        wx0 = TOP_W'(1 << FRAC_W) - wx1;
        for (int ch = 0; ch < 3; ch++)
        begin
            b1_top_next[ch] = TOP_W'(p00_reg[CH_W*ch +: CH_W]) * wx0
                            + TOP_W'(p10_reg[CH_W*ch +: CH_W]) * wx1;
            b1_bot_next[ch] = TOP_W'(p01_reg[CH_W*ch +: CH_W]) * wx0
                            + TOP_W'(rdata[CH_W*ch +: CH_W]) * wx1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= b1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_valid_next)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                b1_top_reg[ch] <= b1_top_next[ch];
                b1_bot_reg[ch] <= b1_bot_next[ch];
            end
            b1_fy_reg  <= rd.fy;
            b1_col_reg <= rd.col;
            b1_row_reg <= rd.row;
        end
    end

    // vertical blend, truncate the q16 sum and saturate
    always_comb
    begin
        logic [SUM_W-1:0]        wy1;
        logic [SUM_W-1:0]        wy0;
        logic [SUM_W-1:0]        sum;
        logic [SUM_W-17:0]       q;
        wy1 = SUM_W'(b1_fy_reg);
        wy0 = SUM_W'(1 << FRAC_W) - wy1;
        sum = '0;
        q   = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = SUM_W'(b1_top_reg[ch]) * wy0 + SUM_W'(b1_bot_reg[ch]) * wy1;
            q   = sum[SUM_W-1:16];
            if (q > (SUM_W-16)'(255))
            begin
                chan_out[ch] = 8'hff;
            end
            else
            begin
                chan_out[ch] = q[CH_W-1:0];
            end
        end
    end

    assign res.valid      = b1_valid_reg;
    assign res.data.col   = b1_col_reg;
    assign res.data.row   = b1_row_reg;
    assign res.data.red   = chan_out[2];
    assign res.data.green = chan_out[1];
    assign res.data.blue  = chan_out[0];

endmodule
`default_nettype wire

FILE: bench/bilinear_thumbnail_scaler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_thumbnail_scaler_test
// Self-checking bench for the bilinear thumbnail scaler. Source pixels are
// written ahead of every request that would read them, each request result is
// predicted from a shadow copy of the frame store and the scale registers, and
// the results are compared in order under random idle and stall on both sides.
// ----------------------------------------------------------------------------
module bilinear_thumbnail_scaler_test;
    import bts_pkg::*;

    localparam int IDLE_PCT    = 26;
    localparam int SETTLE      = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int ITEM_TARGET = 1800;
    localparam int UNIT_POS    = 4096;
    localparam logic [IDX_REG_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic            mode;
        logic [CH_W-1:0] col;
        logic [CH_W-1:0] row;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } scaler_item_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_REG_W-1:0] cfg_index = '0;
    logic [SCALE_W-1:0]   cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 mode      = MODE_WRITE;
    logic [CH_W-1:0]      col       = '0;
    logic [CH_W-1:0]      row       = '0;
    logic [CH_W-1:0]      red_in    = '0;
    logic [CH_W-1:0]      green_in  = '0;
    logic [CH_W-1:0]      blue_in   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CH_W-1:0]      out_col;
    logic [CH_W-1:0]      out_row;
    logic [CH_W-1:0]      red_out;
    logic [CH_W-1:0]      green_out;
    logic [CH_W-1:0]      blue_out;

    bilinear_thumbnail_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .col       (col),
        .row       (row),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_col   (out_col),
        .out_row   (out_row),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    scaler_item_t pix_jobs[$];
    scaler_item_t next_job;
    result_t      awaited_px[$];

    // shadow frame store and register copies seen by the checker
    logic [PIX_W-1:0] shadow_frame [0:DEPTH-1];
    logic [CFG_W-1:0] live_w     = 9'd256;
    logic [CFG_W-1:0] live_h     = 9'd256;
    logic [SCALE_W-1:0] live_scale = 16'd4096;

    // stimulus side view: which pixels hold data and what was programmed
    bit               pix_written [0:DEPTH-1];
    logic [CFG_W-1:0] gen_w     = 9'd256;
    logic [CFG_W-1:0] gen_h     = 9'd256;
    logic [SCALE_W-1:0] gen_scale = 16'd4096;

    int  items_queued = 0;
    int  items_taken  = 0;
    int  quiet_cycles = 0;
    int  fail_count   = 0;
    bit  calm         = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // map one output coordinate to its two source indexes and 8-bit fraction
    function automatic void src_axis(input logic [CH_W-1:0] o, input logic [CFG_W-1:0] size_reg,
                                     input logic [SCALE_W-1:0] scale,
                                     output int unsigned i0, output int unsigned i1,
                                     output int unsigned fr);
        int unsigned lim;
        int unsigned prod;
        int unsigned pos;
        if (size_reg == '0)
            lim = 0;
        else if (size_reg > MAX_SRC_WIDTH)
            lim = MAX_SRC_WIDTH - 1;
        else
            lim = size_reg - 1;
        prod = (2 * int'(o) + 1) * int'(scale);
        pos  = (prod > UNIT_POS) ? prod - UNIT_POS : 0;
        i0   = pos >> 13;
        if (i0 > lim)
            i0 = lim;
        i1 = (i0 + 1 > lim) ? lim : i0 + 1;
        fr = (pos >> 5) & 8'hff;
    endfunction

    function automatic logic [CH_W-1:0] blend_ch(input int unsigned c00, c10, c01, c11,
                                                 input int unsigned fx, fy);
        int unsigned top;
        int unsigned bot;
        int unsigned mix;
        top = c00 * (256 - fx) + c10 * fx;
        bot = c01 * (256 - fx) + c11 * fx;
        mix = (top * (256 - fy) + bot * fy) >> 16;
        return (mix > 255) ? 8'hff : mix[7:0];
    endfunction

    function automatic result_t scale_pixel(input logic [CH_W-1:0] oc, input logic [CH_W-1:0] orow);
        int unsigned x0, x1, y0, y1, fx, fy;
        logic [PIX_W-1:0] q00, q10, q01, q11;
        result_t px;
        src_axis(oc, live_w, live_scale, x0, x1, fx);
        src_axis(orow, live_h, live_scale, y0, y1, fy);
        q00 = shadow_frame[{y0[7:0], x0[7:0]}];
        q10 = shadow_frame[{y0[7:0], x1[7:0]}];
        q01 = shadow_frame[{y1[7:0], x0[7:0]}];
        q11 = shadow_frame[{y1[7:0], x1[7:0]}];
        px.col   = oc;
        px.row   = orow;
        px.red   = blend_ch(q00[23:16], q10[23:16], q01[23:16], q11[23:16], fx, fy);
        px.green = blend_ch(q00[15:8], q10[15:8], q01[15:8], q11[15:8], fx, fy);
        px.blue  = blend_ch(q00[7:0], q10[7:0], q01[7:0], q11[7:0], fx, fy);
        return px;
    endfunction

    function automatic void queue_write(input int unsigned x, input int unsigned y,
                                        input logic [PIX_W-1:0] rgb);
        scaler_item_t job;
        job.mode  = MODE_WRITE;
        job.col   = x[7:0];
        job.row   = y[7:0];
        job.red   = rgb[23:16];
        job.green = rgb[15:8];
        job.blue  = rgb[7:0];
        pix_written[{y[7:0], x[7:0]}] = 1'b1;
        pix_jobs.push_back(job);
        items_queued++;
    endfunction

    function automatic void seed_pixel(input int unsigned x, input int unsigned y);
        if (!pix_written[{y[7:0], x[7:0]}])
            queue_write(x, y, PIX_W'($urandom));
    endfunction

    // every neighbour a request will read gets written first
    function automatic void queue_request(input int unsigned oc, input int unsigned orow);
        int unsigned x0, x1, y0, y1, fx, fy;
        scaler_item_t job;
        src_axis(oc[7:0], gen_w, gen_scale, x0, x1, fx);
        src_axis(orow[7:0], gen_h, gen_scale, y0, y1, fy);
        seed_pixel(x0, y0);
        seed_pixel(x1, y0);
        seed_pixel(x0, y1);
        seed_pixel(x1, y1);
        job.mode  = MODE_REQUEST;
        job.col   = oc[7:0];
        job.row   = orow[7:0];
        job.red   = CH_W'($urandom);
        job.green = CH_W'($urandom);
        job.blue  = CH_W'($urandom);
        pix_jobs.push_back(job);
        items_queued++;
    endfunction

    // number of output pixels that land inside the source along one axis
    function automatic int unsigned out_span(input logic [CFG_W-1:0] size_reg);
        int unsigned eff;
        int unsigned span;
        if (size_reg == '0)
            eff = 1;
        else if (size_reg > MAX_SRC_WIDTH)
            eff = MAX_SRC_WIDTH;
        else
            eff = size_reg;
        if (gen_scale == '0)
            span = 256;
        else
            span = (eff * UNIT_POS + gen_scale - 1) / gen_scale;
        if (span > 256)
            span = 256;
        if (span < 1)
            span = 1;
        return span;
    endfunction

    task automatic write_reg(input logic [IDX_REG_W-1:0] idx, input logic [SCALE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SRC_WIDTH:  gen_w = val[CFG_W-1:0];
            CFG_SRC_HEIGHT: gen_h = val[CFG_W-1:0];
            CFG_INV_SCALE:  gen_scale = val;
            default: ;
        endcase
    endtask

    // upper data bits of the size registers are junk and must be dropped
    task automatic program_scaler(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                  input logic [SCALE_W-1:0] scale);
        write_reg(CFG_SRC_WIDTH, {7'($urandom), w});
        write_reg(CFG_UNUSED, SCALE_W'($urandom));
        write_reg(CFG_SRC_HEIGHT, {7'($urandom), h});
        write_reg(CFG_INV_SCALE, scale);
    endtask

    task automatic wait_idle(input int extra);
        while (items_taken != items_queued || awaited_px.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic random_traffic(input int n);
        int k;
        int pick;
        int unsigned span_x;
        int unsigned span_y;
        span_x = out_span(gen_w);
        span_y = out_span(gen_h);
        for (k = 0; k < n && items_queued < ITEM_TARGET; k++)
        begin
            // hold the sender until every pending result is out
            if (k == n / 2)
                wait_idle(0);
            pick = $urandom_range(99);
            if (pick < 20)
                queue_write($urandom_range(255), $urandom_range(255), PIX_W'($urandom));
            else if (pick < 80)
                queue_request($urandom_range(span_x - 1), $urandom_range(span_y - 1));
            else
                queue_request($urandom_range(255), $urandom_range(255));
        end
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pix_jobs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                next_job = pix_jobs.pop_front();
                in_valid <= 1'b1;
                mode     <= next_job.mode;
                col      <= next_job.col;
                row      <= next_job.row;
                red_in   <= next_job.red;
                green_in <= next_job.green;
                blue_in  <= next_job.blue;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic check_field(input string what, input logic [CH_W-1:0] want,
                               input logic [CH_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    // monitor: tracks registers and frame store, predicts and checks results
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            live_w     = 9'd256;
            live_h     = 9'd256;
            live_scale = 16'd4096;
            quiet_cycles <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SRC_WIDTH:  live_w = cfg_data[CFG_W-1:0];
                    CFG_SRC_HEIGHT: live_h = cfg_data[CFG_W-1:0];
                    CFG_INV_SCALE:  live_scale = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_WRITE)
                    shadow_frame[{row, col}] = {red_in, green_in, blue_in};
                else
                    awaited_px.push_back(scale_pixel(col, row));
                items_taken <= items_taken + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_px.size() == 0)
                begin
                    $display("%0t ns: result transfer with nothing expected, col %0d row %0d",
                             $time, out_col, out_row);
                    fail_count++;
                end
                else
                begin
                    want = awaited_px.pop_front();
                    check_field("out_col", want.col, out_col);
                    check_field("out_row", want.row, out_row);
                    check_field("red_out", want.red, red_out);
                    check_field("green_out", want.green, green_out);
                    check_field("blue_out", want.blue, blue_out);
                end
            end
            if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("bilinear_thumbnail_scaler_test: FAIL");
        $finish;
    end

    initial
    begin
        int ph;
        int unsigned w_pick;
        int unsigned h_pick;
        int unsigned s_pick;
        int unsigned s_alt;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: corners, overwrite, identity scale
        queue_write(0, 0, 24'h000000);
        queue_write(255, 255, 24'hffffff);
        queue_write(255, 0, 24'hff00ff);
        queue_write(0, 255, 24'h00ff00);
        queue_write(0, 0, 24'h123456);
        queue_request(0, 0);
        queue_request(255, 255);
        queue_request(255, 0);
        queue_request(0, 255);
        queue_request(100, 37);
        wait_idle(SETTLE);

        // smallest image and smallest step
        program_scaler(9'd1, 9'd1, 16'd1);
        queue_request(0, 0);
        queue_request(255, 255);
        wait_idle(SETTLE);

        // zero sizes act as one, zero step pins everything to the origin
        program_scaler(9'd0, 9'd0, 16'd0);
        queue_request(255, 255);
        queue_request(9, 140);
        wait_idle(SETTLE);

        // oversized sizes and largest step: far edge clamp
        program_scaler(9'd511, 9'd300, 16'hffff);
        queue_request(0, 0);
        queue_request(255, 255);
        queue_request(1, 0);
        wait_idle(SETTLE);

        // upscale with fractional weights
        program_scaler(9'd256, 9'd256, 16'd2731);
        queue_request(3, 5);
        queue_request(255, 254);
        queue_request(77, 200);

        for (ph = 0; items_queued < ITEM_TARGET; ph++)
        begin
            wait_idle(SETTLE);
            case (ph)
                0: program_scaler(9'd64, 9'd48, 16'd1310);
                1: program_scaler(9'd250, 9'd180, 16'd5120);
                2: program_scaler(9'd256, 9'd256, 16'd4096);
                default:
                begin
                    w_pick = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 256);
                    h_pick = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 256);
                    // software step is max(w/200, h/150) in Q4.12
                    s_pick = (w_pick * UNIT_POS) / 200;
                    s_alt  = (h_pick * UNIT_POS) / 150;
                    if (s_alt > s_pick)
                        s_pick = s_alt;
                    case ($urandom_range(3))
                        0: s_pick = $urandom_range(1, 65535);
                        1: s_pick = $urandom_range(1, 8192);
                        default: if (s_pick == 0) s_pick = 1;
                    endcase
                    program_scaler(w_pick[8:0], h_pick[8:0], s_pick[15:0]);
                end
            endcase
            calm <= (ph == 1);
            random_traffic(150);
        end

        wait_idle(SETTLE);
        if (awaited_px.size() != 0)
        begin
            $display("%0t ns: %0d expected results never arrived", $time, awaited_px.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("bilinear_thumbnail_scaler_test: PASS");
        else
            $display("bilinear_thumbnail_scaler_test: FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/bts_pkg.sv
rtl/bts_frame_store.sv
rtl/bts_blend.sv
rtl/bilinear_thumbnail_scaler.sv
bench/bilinear_thumbnail_scaler_test.sv
